[rtl/sset_pkg.sv]
// Shared types and constants for the sorted set block.
// Used by sset_ctrl, sset_dp and sorted_set_insert_search_delete; no dependencies.
package sset_pkg;

   // Default table size
   localparam int CAPACITY_DEFAULT = 64;

   // Field widths
   localparam int ACTION_W      = 2;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 7;

   // Request kinds
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_SCAN_STEP,
      OP_SCAN_HIT,
      OP_INS_START,
      OP_INS_STEP,
      OP_INS_LAST,
      OP_DEL_START,
      OP_DEL_STEP,
      OP_DEL_LAST,
      OP_COUNT_DEC
   } dp_op_type;

   // Controller to datapath command
   typedef struct packed {
      dp_op_type op;
      logic      set_status;
      logic      emit;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic count_zero;   // table is empty
      logic hit;          // entry read is not less than the request value
      logic next_is_end;  // index + 1 equals the entry count
      logic at_end;       // index equals the entry count
      logic del_last;     // index + 2 equals the entry count
      logic present;      // request value was found
      logic full;         // table holds CAPACITY entries
      logic is_ins;       // request is an insert
      logic is_del;       // request is a delete
   } dp_stat_type;

endpackage

[rtl/sorted_set_insert_search_delete.sv]
// Sorted set of distinct signed 32-bit values with search, insert and delete.
// Top level: joins sset_ctrl and sset_dp. Depends on sset_pkg.
//
// Usage:
//   Request channel req_*: one word per request, action in req_tuser, value in
//   req_tdata. Result channel rsp_*: one word per request, found and status in
//   rsp_tuser, entry count after the request in rsp_tdata.
//   One request is worked on at a time. A request scans the table from the
//   bottom up to the position where its value lands; an insert that stores the
//   value then ripples the entries above it up, and a delete that removes it
//   pulls the entries above it down. The scan and the shift both go through the
//   single read and single write port of the value table, one entry per cycle.
//   The result sits in an output register; the next request is accepted while
//   it waits. If the receiver stalls, the following request completes its work
//   and then holds in its last step until the result register is taken.
//   Reset empties the table at once (no clearing pass) and drops any pending
//   result.
module sorted_set_insert_search_delete #(
   parameter int CAPACITY = sset_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] entry_count, [7] zero
   output logic [2:0]  rsp_tuser    // [0] found, [2:1] status
);

   sset_pkg::dp_cmd_type                cmd;
   sset_pkg::dp_stat_type               stat;
   logic                                rsp_found;
   logic [sset_pkg::STATUS_W-1:0]       rsp_status;
   logic [sset_pkg::ENTRY_COUNT_W-1:0]  rsp_entry_count;

   // Sequencer
   sset_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Table and result datapath
   sset_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_tuser),
      .req_value       (req_tdata),
      .rsp_found       (rsp_found),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // Pack result word
   assign rsp_tdata = {1'b0, rsp_entry_count};
   assign rsp_tuser = {rsp_status, rsp_found};

endmodule

[rtl/sset_dp.sv]
// Datapath of the sorted set: value table memory, scan index, entry count,
// ripple carry for shifting, and the result register. Depends on sset_pkg.
module sset_dp #(
   parameter int CAPACITY = sset_pkg::CAPACITY_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sset_pkg::dp_cmd_type                   cmd,
   output sset_pkg::dp_stat_type                  stat,
   input  logic [sset_pkg::ACTION_W-1:0]          req_action,
   input  logic [sset_pkg::VALUE_W-1:0]           req_value,
   output logic                                   rsp_found,
   output logic [sset_pkg::STATUS_W-1:0]          rsp_status,
   output logic [sset_pkg::ENTRY_COUNT_W-1:0]     rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // Value table, ascending by signed value
   logic        [sset_pkg::VALUE_W-1:0] mem_ff [CAPACITY];
   logic signed [sset_pkg::VALUE_W-1:0] rd_data_ff;
   logic        [AW-1:0]                rd_addr;
   logic                                wr_en;
   logic        [sset_pkg::VALUE_W-1:0] wr_data;

   // Request and working registers
   logic        [sset_pkg::ACTION_W-1:0] act_ff;
   logic signed [sset_pkg::VALUE_W-1:0]  val_ff;
   logic        [sset_pkg::VALUE_W-1:0]  carry_ff;
   logic        [AW-1:0]                 idx_ff;
   logic        [CW-1:0]                 count_ff;
   logic                                 present_ff;
   logic        [sset_pkg::STATUS_W-1:0] status_ff;
   logic        [sset_pkg::STATUS_W-1:0] status_in;

   // Result register
   logic                                    rsp_found_ff;
   logic [sset_pkg::STATUS_W-1:0]           rsp_status_ff;
   logic [sset_pkg::ENTRY_COUNT_W-1:0]      rsp_count_ff;

   logic [CW-1:0] idx_p1;
   logic [CW-1:0] idx_p2;

   assign idx_p1 = CW'(idx_ff) + CW'(1);
   assign idx_p2 = CW'(idx_ff) + CW'(2);

   // Status toward the controller
   always_comb begin
      stat.count_zero  = (count_ff == '0);
      stat.hit         = (rd_data_ff >= val_ff);
      stat.next_is_end = (idx_p1 == count_ff);
      stat.at_end      = (CW'(idx_ff) == count_ff);
      stat.del_last    = (idx_p2 == count_ff);
      stat.present     = present_ff;
      stat.full        = (count_ff == CW'(CAPACITY));
      stat.is_ins      = (act_ff == sset_pkg::ACT_INSERT);
      stat.is_del      = (act_ff == sset_pkg::ACT_DELETE);
   end

   // Select the memory read address for the next cycle
   always_comb begin
      unique case (cmd.op)
         sset_pkg::OP_LOAD:      rd_addr = '0;
         sset_pkg::OP_SCAN_STEP: rd_addr = AW'(idx_p1);
         sset_pkg::OP_INS_START: rd_addr = idx_ff;
         sset_pkg::OP_INS_STEP:  rd_addr = AW'(idx_p1);
         sset_pkg::OP_DEL_START: rd_addr = AW'(idx_p1);
         sset_pkg::OP_DEL_STEP:  rd_addr = AW'(idx_p2);
         default:                rd_addr = idx_ff;
      endcase
   end

   // Shift writes: insert ripples the carry up, delete pulls the next entry down
   always_comb begin
      wr_en   = (cmd.op == sset_pkg::OP_INS_STEP) || (cmd.op == sset_pkg::OP_INS_LAST) ||
                (cmd.op == sset_pkg::OP_DEL_STEP) || (cmd.op == sset_pkg::OP_DEL_LAST);
      wr_data = ((cmd.op == sset_pkg::OP_INS_STEP) || (cmd.op == sset_pkg::OP_INS_LAST))
                ? carry_ff : rd_data_ff;
   end

   // Result status from the request kind and the scan outcome
   always_comb begin
      case (act_ff)
         sset_pkg::ACT_INSERT:
            status_in = present_ff ? sset_pkg::ST_DUP :
                        (stat.full ? sset_pkg::ST_FULL : sset_pkg::ST_DONE);
         default:
            status_in = present_ff ? sset_pkg::ST_DONE : sset_pkg::ST_ABSENT;
      endcase
   end

   // Table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[idx_ff] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.op == sset_pkg::OP_INS_LAST) begin
         count_ff <= count_ff + CW'(1);
      end else if ((cmd.op == sset_pkg::OP_DEL_LAST) || (cmd.op == sset_pkg::OP_COUNT_DEC)) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      case (cmd.op) inside
         sset_pkg::OP_LOAD: begin
            act_ff     <= req_action;
            val_ff     <= req_value;
            idx_ff     <= '0;
            present_ff <= 1'b0;
         end
         sset_pkg::OP_SCAN_STEP: idx_ff <= AW'(idx_p1);
         sset_pkg::OP_SCAN_HIT:  present_ff <= (rd_data_ff == val_ff);
         sset_pkg::OP_INS_START: carry_ff <= val_ff;
         sset_pkg::OP_INS_STEP, sset_pkg::OP_INS_LAST: begin
            carry_ff <= rd_data_ff;
            idx_ff   <= AW'(idx_p1);
         end
         sset_pkg::OP_DEL_STEP, sset_pkg::OP_DEL_LAST: idx_ff <= AW'(idx_p1);
         default: ;
      endcase
      if (cmd.set_status) begin
         status_ff <= status_in;
      end
   end

   // Result register, loaded when the controller emits a word
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff  <= present_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= sset_pkg::ENTRY_COUNT_W'(count_ff);
      end
   end

   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

[rtl/sset_ctrl.sv]
// Controller of the sorted set: sequences scan, insert ripple and delete shift,
// and owns the result valid flag. Depends on sset_pkg.
module sset_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output sset_pkg::dp_cmd_type  cmd,
   input  sset_pkg::dp_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_INS,
      S_DEL,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      cmd.op         = sset_pkg::OP_NOP;
      cmd.set_status = 1'b0;
      cmd.emit       = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = sset_pkg::OP_LOAD;
               state_in = stat.count_zero ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            // stop at the first entry not below the value, or past the last one
            if (stat.hit) begin
               cmd.op   = sset_pkg::OP_SCAN_HIT;
               state_in = S_DECIDE;
            end else begin
               cmd.op = sset_pkg::OP_SCAN_STEP;
               if (stat.next_is_end) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            cmd.set_status = 1'b1;
            if (stat.is_ins && !stat.present && !stat.full) begin
               cmd.op   = sset_pkg::OP_INS_START;
               state_in = S_INS;
            end else if (stat.is_del && stat.present) begin
               if (stat.next_is_end) begin
                  cmd.op   = sset_pkg::OP_COUNT_DEC;
                  state_in = S_FINISH;
               end else begin
                  cmd.op   = sset_pkg::OP_DEL_START;
                  state_in = S_DEL;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_INS: begin
            if (stat.at_end) begin
               cmd.op   = sset_pkg::OP_INS_LAST;
               state_in = S_FINISH;
            end else begin
               cmd.op = sset_pkg::OP_INS_STEP;
            end
         end
         S_DEL: begin
            if (stat.del_last) begin
               cmd.op   = sset_pkg::OP_DEL_LAST;
               state_in = S_FINISH;
            end else begin
               cmd.op = sset_pkg::OP_DEL_STEP;
            end
         end
         S_FINISH: begin
            // hold until the result register is free
            if (slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
